[design/gpm_pkg.sv]
// shared types and constants for the graph partition modularity block
package gpm_pkg;

	// input record kinds
	localparam logic [1:0] MODE_NODE   = 2'd0;
	localparam logic [1:0] MODE_EDGE   = 2'd1;
	localparam logic [1:0] MODE_FINISH = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_SAT   = 2'd2;

	// field and store widths
	localparam int COMM_W     = 8;
	localparam int COMM_COUNT = 256;
	localparam int DEG_W      = 16;
	localparam int VOL_W      = 22;
	localparam int INT_W      = 21;
	localparam int EDGE_W     = 21;
	localparam int FRAC_BITS  = 16;
	localparam int Q_W        = FRAC_BITS + 1;
	localparam int SOUT_W     = 43;

	localparam logic [COMM_W-1:0] COMM_LAST  = COMM_W'(COMM_COUNT - 1);
	localparam logic [EDGE_W-1:0] EDGE_LIMIT = EDGE_W'(1048576);
	localparam logic [VOL_W-1:0]  VOL_MAX    = {VOL_W{1'b1}};

	// finish arithmetic widths
	localparam int SQ_W    = 2 * VOL_W;
	localparam int SSUM_W  = SQ_W + COMM_W;
	localparam int PROD_W  = 2 * EDGE_W;
	localparam int DEN_W   = PROD_W + 1;
	localparam int MAG_W   = SSUM_W;
	localparam int QUO_W   = 2 * FRAC_BITS;
	localparam int REM_W   = DEN_W + 1;
	localparam int SHIFT_W = DEN_W + FRAC_BITS;
	localparam int CNT_W   = $clog2(QUO_W + 1);

	localparam logic [SSUM_W-1:0] SSUM_MAX  = SSUM_W'(64'd4398046511104);
	localparam logic [QUO_W-1:0]  Q_POS_MAX = QUO_W'((64'd1 << FRAC_BITS) - 64'd1);
	localparam logic [QUO_W-1:0]  Q_NEG_MAX = QUO_W'(64'd1 << (FRAC_BITS - 1));

	// request to the quotient unit
	typedef struct packed {
		logic             start;
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic [DEN_W-1:0] den;
	} div_req_t;

	// answer from the quotient unit
	typedef struct packed {
		logic                  done;
		logic signed [Q_W-1:0] q;
	} div_res_t;

endpackage

[design/gpm_store.sv]
// per-community store: synchronous memory with valid bits, one read and one write port
module gpm_store import gpm_pkg::*; #(
	parameter int WIDTH = 22
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [COMM_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data,
	input  logic              wr_en,
	input  logic [COMM_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              clr
);

	logic [WIDTH-1:0]      mem [COMM_COUNT];
	logic [COMM_COUNT-1:0] valid_q;
	logic [WIDTH-1:0]      rd_data_q;
	logic                  rd_valid_q;

	// memory array, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// valid bits, cleared at once by reset or clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// entry never written since clear reads as zero
	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

[design/gpm_divider.sv]
// bit-serial scaled quotient with saturation for the modularity value
module gpm_divider import gpm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_res_t res
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [QUO_W-1:0] num_q;
	logic [QUO_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic             sat_q;
	div_res_t         res_q;

	logic [REM_W-1:0] trial;
	logic             fits;
	logic             sat_c;
	logic [QUO_W-1:0] limit;
	logic [QUO_W-1:0] res_mag;

	// one quotient bit per step
	assign trial = {rem_q[REM_W-2:0], num_q[QUO_W-1]};
	assign fits  = trial >= REM_W'(den_q);

	// a quotient whose integer part is 2^16 or more saturates at once
	assign sat_c = SHIFT_W'(req.mag) >= {req.den, {FRAC_BITS{1'b0}}};

	// clamp to the signed range of the result
	assign limit   = neg_q ? Q_NEG_MAX : Q_POS_MAX;
	assign res_mag = (sat_q || quo_q > limit) ? limit : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			num_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
			neg_q  <= 1'b0;
			sat_q  <= 1'b0;
			res_q  <= '0;
		end else begin
			// done pulses for one cycle when the last step is reached
			res_q.done <= busy_q && !req.start && (sat_q || cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
				rem_q  <= REM_W'(req.mag >> FRAC_BITS);
				num_q  <= {req.mag[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
				quo_q  <= '0;
				den_q  <= req.den;
				neg_q  <= req.neg;
				sat_q  <= sat_c;
			end else if (busy_q) begin
				if (sat_q || cnt_q == '0) begin
					busy_q     <= 1'b0;
					res_q.q    <= neg_q ? -Q_W'(res_mag[Q_W-1:0]) : Q_W'(res_mag[Q_W-1:0]);
				end else begin
					rem_q <= fits ? trial - REM_W'(den_q) : trial;
					quo_q <= {quo_q[QUO_W-2:0], fits};
					num_q <= {num_q[QUO_W-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign res = res_q;

endmodule

[design/graph_partition_modularity_top.sv]
// Newman modularity of a graph partition: node/edge accumulation and finish reduction
// Node and edge items: one item per cycle outside a finish, no result; the store
//   update is a read-modify-write with a one-entry forward of the previous write.
// Finish item: the result comes from the 256-entry walk over the single read port
//   of each store and, when edges were seen, the 32-step serial quotient unit.
// Reset: asynchronous, clears all control, counters and store valid bits, so every
//   community reads as zero at once; no clearing pass.
module graph_partition_modularity_top import gpm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [COMM_W-1:0]     community_a,
	input  logic [COMM_W-1:0]     community_b,
	input  logic [DEG_W-1:0]      degree,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [Q_W-1:0] q_fixed,
	output logic [INT_W-1:0]      internal_edges,
	output logic [SOUT_W-1:0]     volume_square_sum,
	output logic [EDGE_W-1:0]     edge_total,
	output logic [1:0]            status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t state_q;

	logic              in_acc;
	logic              node_go;
	logic              edge_go;
	logic              fin_go;
	logic              int_go;
	logic              edge_room;
	logic              walking;
	logic              store_clr;
	logic [COMM_W-1:0] rd_addr;

	logic [COMM_W-1:0] walk_idx_q;
	logic [EDGE_W-1:0] edge_count_q;
	logic              ovf_q;

	// update pipeline
	logic              vol_we_s2;
	logic              int_we_s2;
	logic [COMM_W-1:0] addr_s2;
	logic [DEG_W-1:0]  deg_s2;
	logic              vol_last_we_q;
	logic              int_last_we_q;
	logic [COMM_W-1:0] last_addr_q;
	logic [VOL_W-1:0]  vol_last_q;
	logic [INT_W-1:0]  int_last_q;
	logic [VOL_W-1:0]  vol_rd;
	logic [INT_W-1:0]  int_rd;
	logic [VOL_W-1:0]  vol_old;
	logic [VOL_W:0]    vol_sum;
	logic [VOL_W-1:0]  vol_new;
	logic [INT_W-1:0]  int_old;
	logic [INT_W-1:0]  int_new;

	// finish walk and reduction
	logic              walk_rd_s1;
	logic              sq_vld_s2;
	logic [SQ_W-1:0]   sq_s2;
	logic [INT_W-1:0]  int_s2;
	logic [SSUM_W-1:0] s_acc_q;
	logic [INT_W-1:0]  e_acc_q;
	logic [PROD_W-1:0] me_q;
	logic [PROD_W-1:0] mm_q;
	logic [DEN_W-1:0]  four_me;
	logic [MAG_W-1:0]  four_me_ext;
	logic              num_neg;
	logic [MAG_W-1:0]  num_mag;
	logic [DEN_W-1:0]  den;
	div_req_t          div_req_q;
	div_res_t          div_res;
	logic signed [Q_W-1:0] q_res_q;
	logic [1:0]        status_q;

	// result register
	logic                  out_valid_q;
	logic signed [Q_W-1:0] out_q_q;
	logic [INT_W-1:0]      out_int_q;
	logic [SOUT_W-1:0]     out_ssum_q;
	logic [EDGE_W-1:0]     out_edge_q;
	logic [1:0]            out_status_q;

	// item decode at accept
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign edge_room = edge_count_q < EDGE_LIMIT;

	always_comb begin
		node_go = 1'b0;
		edge_go = 1'b0;
		fin_go  = 1'b0;
		unique case (mode)
			MODE_NODE:   node_go = in_acc;
			MODE_EDGE:   edge_go = in_acc;
			MODE_FINISH: fin_go  = in_acc;
			default: ;
		endcase
	end

	assign int_go    = edge_go && edge_room && (community_a == community_b);
	assign walking   = (state_q == ST_WALK);
	assign store_clr = walking && (walk_idx_q == COMM_LAST);
	assign rd_addr   = walking ? walk_idx_q : community_a;

	// stores
	gpm_store #(
		.WIDTH(VOL_W)
	) u_vol_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (node_go || walking),
		.rd_addr (rd_addr),
		.rd_data (vol_rd),
		.wr_en   (vol_we_s2),
		.wr_addr (addr_s2),
		.wr_data (vol_new),
		.clr     (store_clr)
	);

	gpm_store #(
		.WIDTH(INT_W)
	) u_int_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (int_go || walking),
		.rd_addr (rd_addr),
		.rd_data (int_rd),
		.wr_en   (int_we_s2),
		.wr_addr (addr_s2),
		.wr_data (int_new),
		.clr     (store_clr)
	);

	// modify stage with forward of the write made in the cycle before
	assign vol_old = (vol_last_we_q && last_addr_q == addr_s2) ? vol_last_q : vol_rd;
	assign vol_sum = {1'b0, vol_old} + (VOL_W + 1)'(deg_s2);
	assign vol_new = vol_sum[VOL_W] ? VOL_MAX : vol_sum[VOL_W-1:0];
	assign int_old = (int_last_we_q && last_addr_q == addr_s2) ? int_last_q : int_rd;
	assign int_new = int_old + 1'b1;

	// update pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_we_s2     <= 1'b0;
			int_we_s2     <= 1'b0;
			vol_last_we_q <= 1'b0;
			int_last_we_q <= 1'b0;
		end else begin
			vol_we_s2     <= node_go;
			int_we_s2     <= int_go;
			vol_last_we_q <= vol_we_s2;
			int_last_we_q <= int_we_s2;
		end
	end

	// update pipeline payload
	always_ff @(posedge clk) begin
		addr_s2     <= community_a;
		deg_s2      <= degree;
		last_addr_q <= addr_s2;
		vol_last_q  <= vol_new;
		int_last_q  <= int_new;
	end

	// walk pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_rd_s1 <= 1'b0;
			sq_vld_s2  <= 1'b0;
		end else begin
			walk_rd_s1 <= walking;
			sq_vld_s2  <= walk_rd_s1;
		end
	end

	// square each volume, then accumulate the squares and the internal counts
	always_ff @(posedge clk) begin
		sq_s2  <= vol_rd * vol_rd;
		int_s2 <= int_rd;
		if (fin_go) begin
			s_acc_q <= '0;
			e_acc_q <= '0;
		end else if (sq_vld_s2) begin
			s_acc_q <= s_acc_q + SSUM_W'(sq_s2);
			e_acc_q <= e_acc_q + int_s2;
		end
	end

	// numerator 4mE - S as sign and magnitude, denominator 4m^2
	assign four_me     = {me_q[PROD_W-2:0], 2'b00};
	assign four_me_ext = MAG_W'(four_me);
	assign num_neg     = s_acc_q > four_me_ext;
	assign num_mag     = num_neg ? s_acc_q - four_me_ext : four_me_ext - s_acc_q;
	assign den         = {mm_q[PROD_W-2:0], 2'b00};

	gpm_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.res    (div_res)
	);

	// sequencer, edge counter and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			walk_idx_q   <= '0;
			edge_count_q <= '0;
			ovf_q        <= 1'b0;
			me_q         <= '0;
			mm_q         <= '0;
			div_req_q    <= '0;
			q_res_q      <= '0;
			status_q     <= STATUS_OK;
			out_valid_q  <= 1'b0;
			out_q_q      <= '0;
			out_int_q    <= '0;
			out_ssum_q   <= '0;
			out_edge_q   <= '0;
			out_status_q <= STATUS_OK;
		end else begin
			// quotient unit starts from the prep state when edges were seen
			div_req_q.start <= (state_q == ST_PREP) && (edge_count_q != '0);
			// result leaves when taken; the hold state reloads it itself
			if (out_valid_q && out_ready && state_q != ST_HOLD) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (edge_go) begin
						if (edge_room) begin
							edge_count_q <= edge_count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					if (fin_go) begin
						walk_idx_q <= '0;
						state_q    <= ST_WALK;
					end
				end
				ST_WALK: begin
					walk_idx_q <= walk_idx_q + 1'b1;
					if (walk_idx_q == COMM_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!walk_rd_s1 && !sq_vld_s2) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					me_q    <= edge_count_q * e_acc_q;
					mm_q    <= edge_count_q * edge_count_q;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (edge_count_q == '0) begin
						q_res_q  <= '0;
						status_q <= STATUS_EMPTY;
						state_q  <= ST_HOLD;
					end else begin
						div_req_q.neg   <= num_neg;
						div_req_q.mag   <= num_mag;
						div_req_q.den   <= den;
						status_q        <= ovf_q ? STATUS_SAT : STATUS_OK;
						state_q         <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						q_res_q <= div_res.q;
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_q_q      <= q_res_q;
						out_int_q    <= e_acc_q;
						out_ssum_q   <= (s_acc_q > SSUM_MAX) ? SOUT_W'(SSUM_MAX) :
							s_acc_q[SOUT_W-1:0];
						out_edge_q   <= edge_count_q;
						out_status_q <= status_q;
						edge_count_q <= '0;
						ovf_q        <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign q_fixed           = out_q_q;
	assign internal_edges    = out_int_q;
	assign volume_square_sum = out_ssum_q;
	assign edge_total        = out_edge_q;
	assign status            = out_status_q;

	// no item is taken while the walk pipeline still holds store data
	a_ready_walk_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !walk_rd_s1 && !sq_vld_s2)
		else $error("item accepted while finish walk in flight");

	// edge count never passes its bound
	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_count_q <= EDGE_LIMIT)
		else $error("edge count beyond limit");

	// a result appears only out of the hold state
	a_out_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_HOLD))
		else $error("result raised outside hold state");

	// an empty graph reports zero modularity and zero edges
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_EMPTY |-> q_fixed == '0 && edge_total == '0)
		else $error("empty status with nonzero result");

	// no store update lands during the walk
	a_no_write_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walking |-> !vol_we_s2 && !int_we_s2)
		else $error("store write during finish walk");

endmodule

[tb/modularity_checker.sv]
// checker for the modularity block: follows both channels, predicts each result and compares
module modularity_checker import gpm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [COMM_W-1:0]     community_a,
	input  logic [COMM_W-1:0]     community_b,
	input  logic [DEG_W-1:0]      degree,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic signed [Q_W-1:0] q_fixed,
	input  logic [INT_W-1:0]      internal_edges,
	input  logic [SOUT_W-1:0]     volume_square_sum,
	input  logic [EDGE_W-1:0]     edge_total,
	input  logic [1:0]            status,
	output int                    fail_count,
	output int                    pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// one finish result, field by field
	typedef struct packed {
		logic signed [Q_W-1:0] q;
		logic [INT_W-1:0]      internal;
		logic [SOUT_W-1:0]     squares;
		logic [EDGE_W-1:0]     edges;
		logic [1:0]            status;
	} modularity_t;

	localparam longint unsigned SQUARES_CAP = 64'd1 << 42;
	localparam longint unsigned Q_ONE       = 64'd1 << FRAC_BITS;

	// predicted graph state
	logic [VOL_W-1:0]  comm_volume   [COMM_COUNT];
	logic [INT_W-1:0]  comm_internal [COMM_COUNT];
	logic [EDGE_W-1:0] edges_seen;
	bit                edges_capped;

	modularity_t expected_results[$];
	int          failures = 0;

	// trunc(mag * 2^F / den), clamped to the signed output range
	function automatic logic signed [Q_W-1:0] scaled_modularity(bit neg, longint unsigned mag,
			longint unsigned den);
		longint unsigned whole, rem, cap, res;
		whole = mag / den;
		rem   = mag % den;
		cap   = neg ? (Q_ONE >> 1) : (Q_ONE - 1);
		if (whole >= Q_ONE) begin
			res = cap;
		end else begin
			res = whole;
			for (int i = 0; i < FRAC_BITS; i++) begin
				rem = rem << 1;
				res = res << 1;
				if (rem >= den) begin
					rem = rem - den;
					res = res | 64'd1;
				end
			end
			if (res > cap)
				res = cap;
		end
		return neg ? -Q_W'(res) : Q_W'(res);
	endfunction

	// reduce the stores into one result
	function automatic modularity_t finish_result();
		longint unsigned e_sum, s_sum, m, four_me, den, vol;
		modularity_t r;
		e_sum = 0;
		s_sum = 0;
		m     = edges_seen;
		for (int j = 0; j < COMM_COUNT; j++) begin
			vol   = comm_volume[j];
			e_sum = e_sum + comm_internal[j];
			s_sum = s_sum + vol * vol;
		end
		r.internal = INT_W'(e_sum);
		r.squares  = (s_sum > SQUARES_CAP) ? SOUT_W'(SQUARES_CAP) : SOUT_W'(s_sum);
		r.edges    = edges_seen;
		if (m == 0) begin
			r.q      = '0;
			r.status = STATUS_EMPTY;
		end else begin
			four_me = 4 * m * e_sum;
			den     = 4 * m * m;
			if (s_sum > four_me)
				r.q = scaled_modularity(1'b1, s_sum - four_me, den);
			else
				r.q = scaled_modularity(1'b0, four_me - s_sum, den);
			r.status = edges_capped ? STATUS_SAT : STATUS_OK;
		end
		return r;
	endfunction

	task automatic clear_graph();
		for (int j = 0; j < COMM_COUNT; j++) begin
			comm_volume[j]   = '0;
			comm_internal[j] = '0;
		end
		edges_seen   = '0;
		edges_capped = 1'b0;
	endtask

	// compare results first, then fold in the accepted item
	always @(posedge clk or negedge arst_n) begin
		modularity_t got, want;
		int unsigned vsum;
		if (!arst_n) begin
			clear_graph();
			expected_results.delete();
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {q_fixed, internal_edges, volume_square_sum, edge_total, status};
				if (expected_results.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected result: q %0d internal %0d squares %0d edges %0d status %0d",
							got.q, got.internal, got.squares, got.edges, got.status);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= 10)
							$display({"mismatch (expected/actual): q %0d/%0d internal %0d/%0d ",
								"squares %0d/%0d edges %0d/%0d status %0d/%0d"},
								want.q, got.q, want.internal, got.internal, want.squares,
								got.squares, want.edges, got.edges, want.status, got.status);
					end
				end
			end

			if (in_valid && in_ready) begin
				case (mode)
					MODE_NODE: begin
						vsum = comm_volume[community_a] + degree;
						comm_volume[community_a] = (vsum > VOL_MAX) ? VOL_MAX : VOL_W'(vsum);
					end
					MODE_EDGE: begin
						if (edges_seen >= EDGE_LIMIT) begin
							edges_capped = 1'b1;
						end else begin
							edges_seen++;
							if (community_a == community_b)
								comm_internal[community_a]++;
						end
					end
					MODE_FINISH: begin
						expected_results.insert(expected_results.size(), finish_result());
						clear_graph();
					end
					default: ;
				endcase
			end

			fail_count    <= failures;
			pending_count <= expected_results.size();
		end
	end

endmodule

[tb/tb.sv]
// testbench top for the modularity block: stimulus, receiver stalls and verdict
module tb;
	import gpm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            mode;
	logic [COMM_W-1:0]     community_a;
	logic [COMM_W-1:0]     community_b;
	logic [DEG_W-1:0]      degree;
	logic                  out_valid;
	logic                  out_ready;
	logic signed [Q_W-1:0] q_fixed;
	logic [INT_W-1:0]      internal_edges;
	logic [SOUT_W-1:0]     volume_square_sum;
	logic [EDGE_W-1:0]     edge_total;
	logic [1:0]            status;
	int                    fail_count;
	int                    pending_count;

	int burst_left = 0;
	int items_sent = 0;
	bit steady     = 1'b0;
	bit rand_phase = 1'b0;

	graph_partition_modularity_top DUT (.*);

	modularity_checker score (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// offer one item, in bursts with random gaps unless steady, and wait for acceptance
	task automatic send_item(input logic [1:0] m, input logic [COMM_W-1:0] a,
			input logic [COMM_W-1:0] b, input logic [DEG_W-1:0] d);
		int gap;
		if (!steady && burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		community_a <= a;
		community_b <= b;
		degree      <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (burst_left > 0)
			burst_left--;
		if (m != MODE_UNUSED)
			items_sent++;
	endtask

	// receiver: changing stall styles, one long hold at the start of the random part
	initial begin
		int style, left, hold;
		bit long_hold_done;
		style = 0;
		left = 0;
		hold = 0;
		long_hold_done = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				style = $urandom_range(0, 3);
				left  = $urandom_range(16, 160);
			end
			left--;
			if (rand_phase && !long_hold_done) begin
				long_hold_done = 1'b1;
				hold = 2000;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				case (style)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 7) == 0);
					default: out_ready <= !out_ready;
				endcase
			end
		end
	end

	// stimulus
	initial begin
		int n, k, ne, u, v, kind, cnt, rand_start;
		logic [COMM_W-1:0] base, c;
		logic [COMM_W-1:0] node_comm [24];
		int node_deg [24];
		bit spread;

		in_valid    <= 1'b0;
		mode        <= MODE_NODE;
		community_a <= '0;
		community_b <= '0;
		degree      <= '0;
		arst_n      <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// finish on an empty graph
		send_item(MODE_FINISH, '0, '0, '0);
		// field extremes, ignored mode, then back-to-back finishes
		send_item(MODE_NODE, 8'hFF, 8'h00, 16'hFFFF);
		send_item(MODE_NODE, 8'h00, 8'hFF, 16'h0000);
		send_item(MODE_EDGE, 8'hFF, 8'hFF, 16'h0000);
		send_item(MODE_EDGE, 8'h00, 8'hFF, 16'hFFFF);
		send_item(MODE_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
		send_item(MODE_FINISH, 8'hFF, 8'hFF, 16'hFFFF);
		send_item(MODE_FINISH, '0, '0, '0);
		// only internal edges, no volume: q clamps at the top
		send_item(MODE_EDGE, 8'd5, 8'd5, 16'd0);
		send_item(MODE_EDGE, 8'd5, 8'd5, 16'd0);
		send_item(MODE_FINISH, '0, '0, '0);
		// one crossing edge against a large volume: q clamps at the bottom
		send_item(MODE_NODE, 8'd1, 8'd0, 16'hFFFF);
		send_item(MODE_EDGE, 8'd1, 8'd2, 16'd0);
		send_item(MODE_FINISH, '0, '0, '0);
		// small graph with slightly negative q, truncated toward zero
		send_item(MODE_NODE, 8'd4, 8'd0, 16'd3);
		send_item(MODE_NODE, 8'd4, 8'd0, 16'd2);
		send_item(MODE_NODE, 8'd6, 8'd0, 16'd1);
		send_item(MODE_EDGE, 8'd4, 8'd4, 16'd0);
		send_item(MODE_EDGE, 8'd4, 8'd4, 16'd0);
		send_item(MODE_EDGE, 8'd4, 8'd6, 16'd0);
		send_item(MODE_FINISH, '0, '0, '0);

		// heavy volume on one community and a few edges, sent back to back
		steady = 1'b1;
		for (int i = 0; i < 32; i++)
			send_item(MODE_NODE, 8'd9, 8'($urandom), 16'hFFFF);
		for (int i = 0; i < 5; i++) begin
			c = 8'($urandom);
			send_item(MODE_EDGE, c, (i < 2) ? c : 8'($urandom), 16'($urandom));
		end
		send_item(MODE_FINISH, '0, '0, '0);
		send_item(MODE_FINISH, '0, '0, '0);
		steady = 1'b0;

		// random graphs, heavy volumes, noise
		rand_phase = 1'b1;
		rand_start = items_sent;
		while (items_sent - rand_start < 890) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				// a small graph with consistent node degrees
				n      = $urandom_range(2, 24);
				k      = $urandom_range(1, 6);
				base   = 8'($urandom);
				spread = ($urandom_range(0, 3) == 0);
				for (int i = 0; i < n; i++) begin
					node_comm[i] = spread ? 8'($urandom) : base + 8'($urandom_range(0, k - 1));
					node_deg[i]  = 0;
				end
				ne = $urandom_range(0, 3 * n);
				for (int e = 0; e < ne; e++) begin
					u = $urandom_range(0, n - 1);
					v = $urandom_range(0, n - 2);
					if (v >= u)
						v++;
					node_deg[u]++;
					node_deg[v]++;
					send_item(MODE_EDGE, node_comm[u], node_comm[v], 16'($urandom));
				end
				for (int i = 0; i < n; i++)
					send_item(MODE_NODE, node_comm[i], 8'($urandom), 16'(node_deg[i]));
				if ($urandom_range(0, 7) != 0)
					send_item(MODE_FINISH, 8'($urandom), 8'($urandom), 16'($urandom));
			end else if (kind < 80) begin
				// anything goes, including unused mode
				cnt = $urandom_range(5, 30);
				for (int i = 0; i < cnt; i++)
					send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
						16'($urandom));
				send_item(MODE_FINISH, 8'($urandom), 8'($urandom), 16'($urandom));
			end else if (kind < 85) begin
				// pile volume into one community toward saturation
				c   = 8'($urandom);
				cnt = $urandom_range(60, 80);
				for (int i = 0; i < cnt; i++)
					send_item(MODE_NODE, c, 8'($urandom), 16'($urandom_range(16'hF000, 16'hFFFF)));
				cnt = $urandom_range(0, 6);
				for (int i = 0; i < cnt; i++)
					send_item(MODE_EDGE, 8'($urandom), 8'($urandom), 16'($urandom));
				send_item(MODE_FINISH, 8'($urandom), 8'($urandom), 16'($urandom));
			end else if (kind < 95) begin
				// edges only or nodes only
				if ($urandom_range(0, 1) == 0) begin
					cnt = $urandom_range(1, 40);
					for (int i = 0; i < cnt; i++) begin
						c = 8'($urandom);
						send_item(MODE_EDGE, c, ($urandom_range(0, 1) == 0) ? c : 8'($urandom),
							16'($urandom));
					end
				end else begin
					cnt = $urandom_range(1, 10);
					for (int i = 0; i < cnt; i++)
						send_item(MODE_NODE, 8'($urandom), 8'($urandom), 16'($urandom));
				end
				send_item(MODE_FINISH, 8'($urandom), 8'($urandom), 16'($urandom));
			end else begin
				send_item(MODE_FINISH, 8'($urandom), 8'($urandom), 16'($urandom));
			end
		end
		send_item(MODE_FINISH, '0, '0, '0);
		in_valid <= 1'b0;

		// drain, then allow for any late result
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
design/gpm_pkg.sv
design/gpm_store.sv
design/gpm_divider.sv
design/graph_partition_modularity_top.sv
tb/modularity_checker.sv
tb/tb.sv
